@@ src/zot_pkg.sv @@
// Package for the zone occupancy tracker.
// Holds shared constants, command codes, datapath operations and status.
// No dependencies.
package zot_pkg;

    localparam int MAX_VERTICES_DEF = 8;
    localparam int MAX_TARGETS_DEF  = 3;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [14:0] DIST_MAX      = 15'h7FFF;
    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

    localparam logic [1:0] CMD_VERTEX  = 2'd0;
    localparam logic [1:0] CMD_TARGET  = 2'd1;
    localparam logic [1:0] CMD_UNAVAIL = 2'd2;
    localparam logic [1:0] CMD_SPARE   = 2'd3;

    localparam logic CFG_MARGIN  = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE, OP_VTX_WR, OP_SHORT, OP_UNAVAIL, OP_START, OP_RD, OP_DIFF,
        OP_MX1, OP_MX2, OP_SIGN, OP_LEN0, OP_LEN1, OP_DOT0, OP_DOT1,
        OP_PT0, OP_PT1, OP_MAG, OP_DVI, OP_DVS, OP_SQI, OP_SQS, OP_MIN,
        OP_NEXT, OP_RESULT, OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic vcount_ok;
        logic present;
        logic tracked;
        logic in_zone;
        logic last_edge;
        logic near_start;
        logic near_end;
        logic out_free;
    } t_dp_status;

endpackage

@@ src/zot_ctrl.sv @@
// Controller state machine of the zone occupancy tracker.
// Sequences the datapath edge by edge; depends on zot_pkg.
module zot_ctrl import zot_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic [1:0] i_s_tuser,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_op     o_op
);

    typedef enum logic [4:0] {
        S_IDLE, S_BRANCH, S_RD, S_DIFF, S_MX1, S_MX2, S_SIGN, S_LEN0, S_LEN1,
        S_DOT0, S_DOT1, S_CASE, S_PT0, S_PT1, S_MAG, S_DVI, S_DVS, S_SQI,
        S_SQS, S_MIN, S_NEXT, S_RES, S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    case (i_s_tuser)
                        CMD_VERTEX: o_op = OP_VTX_WR;
                        CMD_TARGET: begin
                            if (i_status.vcount_ok) begin
                                o_op    = OP_START;
                                n_state = S_BRANCH;
                            end else begin
                                o_op = OP_SHORT;
                            end
                        end
                        CMD_UNAVAIL: begin
                            o_op    = OP_UNAVAIL;
                            n_state = S_EMIT;
                        end
                        default: o_op = OP_NONE;
                    endcase
                end
            end
            S_BRANCH: n_state = i_status.present ? S_RD : S_RES;
            S_RD: begin
                o_op    = OP_RD;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_op    = OP_DIFF;
                n_state = S_MX1;
            end
            S_MX1: begin
                o_op    = OP_MX1;
                n_state = S_MX2;
            end
            S_MX2: begin
                o_op    = OP_MX2;
                n_state = S_SIGN;
            end
            S_SIGN: begin
                o_op    = OP_SIGN;
                n_state = i_status.tracked ? S_LEN0 : S_NEXT;
            end
            S_LEN0: begin
                o_op    = OP_LEN0;
                n_state = S_LEN1;
            end
            S_LEN1: begin
                o_op    = OP_LEN1;
                n_state = S_DOT0;
            end
            S_DOT0: begin
                o_op    = OP_DOT0;
                n_state = S_DOT1;
            end
            S_DOT1: begin
                o_op    = OP_DOT1;
                n_state = S_CASE;
            end
            S_CASE: begin
                n_state = (i_status.near_start || i_status.near_end) ? S_PT0 : S_MAG;
            end
            S_PT0: begin
                o_op    = OP_PT0;
                n_state = S_PT1;
            end
            S_PT1: begin
                o_op    = OP_PT1;
                n_state = S_SQI;
            end
            S_MAG: begin
                o_op    = OP_MAG;
                n_state = S_DVI;
            end
            S_DVI: begin
                o_op    = OP_DVI;
                n_cnt   = 5'd31;
                n_state = S_DVS;
            end
            S_DVS: begin
                o_op = OP_DVS;
                if (r_cnt == 5'd0) begin
                    n_state = S_SQI;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_SQI: begin
                o_op    = OP_SQI;
                n_cnt   = 5'd15;
                n_state = S_SQS;
            end
            S_SQS: begin
                o_op = OP_SQS;
                if (r_cnt == 5'd0) begin
                    n_state = S_MIN;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_MIN: begin
                o_op    = OP_MIN;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                o_op = OP_NEXT;
                if (i_status.last_edge || (!i_status.in_zone && !i_status.tracked)) begin
                    n_state = S_RES;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RES: begin
                o_op    = OP_RESULT;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_op    = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

@@ src/zot_datapath.sv @@
// Datapath of the zone occupancy tracker: vertex memory, target state,
// shared multiplier, divider and square root steps, result register.
// Depends on zot_pkg.
module zot_datapath import zot_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_TARGETS  = MAX_TARGETS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_op                 i_op,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tlast,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   i_m_tready,
    output t_dp_status             o_status,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tuser,
    output logic                   o_m_tlast
);

    localparam int VIW = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int TIW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

    logic [2:0]         in_vidx;
    logic               in_lastv;
    logic [1:0]         in_slot;
    logic               in_present;
    logic signed [14:0] in_x, in_y;
    logic [31:0]        in_time;

    assign in_vidx    = i_s_tdata[2:0];
    assign in_lastv   = i_s_tdata[3];
    assign in_slot    = i_s_tdata[5:4];
    assign in_present = i_s_tdata[6];
    assign in_x       = i_s_tdata[21:7];
    assign in_y       = i_s_tdata[36:22];
    assign in_time    = i_s_tdata[68:37];

    logic signed [14:0] r_vx [MAX_VERTICES];
    logic signed [14:0] r_vy [MAX_VERTICES];
    logic signed [14:0] r_ax, r_ay, r_bx, r_by;

    logic [CW-1:0]          r_vcount;
    logic [MAX_TARGETS-1:0] r_tracked;
    logic [31:0]            r_seen [MAX_TARGETS];
    logic [1:0]             r_frame;
    logic [14:0]            r_margin;
    logic [31:0]            r_timeout;

    logic [1:0]         r_slot;
    logic               r_present, r_last;
    logic signed [14:0] r_px, r_py;
    logic [31:0]        r_now;
    logic [VIW-1:0]     r_ia;
    logic [CW-1:0]      r_edge;

    logic signed [15:0] r_ex, r_ey, r_qx, r_qy, r_rx, r_ry;
    logic signed [65:0] r_acc;
    logic signed [32:0] r_cr, r_dot;
    logic [31:0]        r_len2, r_d2, r_rem, r_root, r_bit;
    logic [63:0]        r_num;
    logic               r_prev_pos, r_prev_neg, r_in_zone;
    logic [14:0]        r_min;

    logic       r_res_c, r_res_last, r_res_occ, r_res_cv;
    logic [1:0] r_res_cnt;
    logic       r_m_valid;
    logic       r_m_c, r_m_occ, r_m_last, r_m_cv;
    logic [1:0] r_m_cnt;

    logic               slot_valid, tracked, out_free, near_start, near_end;
    logic [TIW-1:0]     slot_idx;
    logic [VIW-1:0]     ib;
    logic [31:0]        mag;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [32:0]        div_t, sq_sum;
    logic               div_ge, sq_ge, cr_pos, cr_neg, opposite, timed_out;
    logic               res_c, set_track, clr_track;
    logic [1:0]         fc_new;
    logic [14:0]        dsat;

    assign slot_valid = int'(r_slot) < MAX_TARGETS;
    assign slot_idx   = TIW'(r_slot);
    assign tracked    = slot_valid && r_tracked[slot_idx];
    assign out_free   = !r_m_valid || i_m_tready;
    assign ib         = ((CW'(r_ia) + CW'(1)) == r_vcount) ? '0 : VIW'(r_ia + VIW'(1));
    assign mag        = r_cr[32] ? 32'(-r_cr) : r_cr[31:0];
    assign near_start = (r_len2 == 32'd0) || r_dot[32];
    assign near_end   = !near_start && (r_dot > $signed({1'b0, r_len2}));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_op)
            OP_MX1: begin
                mul_a = 33'(r_ex);
                mul_b = 33'(r_qy);
            end
            OP_MX2: begin
                mul_a = 33'(r_ey);
                mul_b = 33'(r_qx);
            end
            OP_LEN0: begin
                mul_a = 33'(r_ex);
                mul_b = 33'(r_ex);
            end
            OP_LEN1: begin
                mul_a = 33'(r_ey);
                mul_b = 33'(r_ey);
            end
            OP_DOT0: begin
                mul_a = 33'(r_ex);
                mul_b = 33'(r_qx);
            end
            OP_DOT1: begin
                mul_a = 33'(r_ey);
                mul_b = 33'(r_qy);
            end
            OP_PT0: begin
                mul_a = near_start ? 33'(r_qx) : 33'(r_rx);
                mul_b = mul_a;
            end
            OP_PT1: begin
                mul_a = near_start ? 33'(r_qy) : 33'(r_ry);
                mul_b = mul_a;
            end
            OP_MAG: begin
                mul_a = $signed({1'b0, mag});
                mul_b = mul_a;
            end
            default: mul_a = '0;
        endcase
    end

    assign prod = mul_a * mul_b;

    assign div_t  = {r_rem, r_num[63]};
    assign div_ge = div_t >= {1'b0, r_len2};
    assign sq_sum = {1'b0, r_root} + {1'b0, r_bit};
    assign sq_ge  = {1'b0, r_rem} >= sq_sum;
    assign cr_neg = r_cr[32];
    assign cr_pos = !r_cr[32] && (r_cr != 33'sd0);
    assign opposite = (cr_pos && r_prev_neg) || (cr_neg && r_prev_pos);
    assign dsat   = (r_root > 32'(DIST_MAX)) ? DIST_MAX : r_root[14:0];
    assign timed_out = (r_now - r_seen[slot_idx]) > r_timeout;

    always_comb begin
        res_c     = 1'b0;
        set_track = 1'b0;
        clr_track = 1'b0;
        if (!r_present) begin
            res_c     = tracked && !timed_out;
            clr_track = tracked && timed_out;
        end else if (r_in_zone) begin
            res_c     = 1'b1;
            set_track = slot_valid;
        end else if (tracked) begin
            res_c     = (r_min <= r_margin);
            clr_track = (r_min > r_margin);
        end
        fc_new = (res_c && r_frame != 2'd3) ? r_frame + 2'd1 : r_frame;
    end

    // Vertex memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_VTX_WR && int'(in_vidx) < MAX_VERTICES) begin
            r_vx[VIW'(in_vidx)] <= in_x;
            r_vy[VIW'(in_vidx)] <= in_y;
        end
        if (i_op == OP_RD) begin
            r_ax <= r_vx[r_ia];
            r_ay <= r_vy[r_ia];
            r_bx <= r_vx[ib];
            r_by <= r_vy[ib];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount  <= '0;
            r_tracked <= '0;
            r_frame   <= 2'd0;
            r_margin  <= 15'd0;
            r_timeout <= TIMEOUT_RESET;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MARGIN:  r_margin  <= i_cfg_wdata[14:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_wdata;
                    default:     r_margin  <= r_margin;
                endcase
            end
            if (i_op == OP_EMIT) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (i_op)
                OP_VTX_WR: begin
                    if (int'(in_vidx) < MAX_VERTICES && in_lastv) begin
                        r_vcount <= CW'(in_vidx) + CW'(1);
                    end
                end
                OP_SHORT: begin
                    if (i_s_tlast) begin
                        r_frame <= 2'd0;
                    end
                end
                OP_UNAVAIL: r_frame <= 2'd0;
                OP_RESULT: begin
                    r_frame <= r_last ? 2'd0 : fc_new;
                    if (set_track) begin
                        r_tracked[slot_idx] <= 1'b1;
                    end
                    if (clr_track) begin
                        r_tracked[slot_idx] <= 1'b0;
                    end
                end
                default: r_frame <= r_frame;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_START: begin
                r_slot     <= in_slot;
                r_present  <= in_present;
                r_last     <= i_s_tlast;
                r_px       <= in_x;
                r_py       <= in_y;
                r_now      <= in_time;
                r_ia       <= '0;
                r_edge     <= '0;
                r_prev_pos <= 1'b0;
                r_prev_neg <= 1'b0;
                r_in_zone  <= 1'b1;
                r_min      <= DIST_MAX;
            end
            OP_UNAVAIL: begin
                r_res_c    <= 1'b0;
                r_res_last <= 1'b1;
                r_res_occ  <= 1'b0;
                r_res_cnt  <= 2'd0;
                r_res_cv   <= 1'b0;
            end
            OP_DIFF: begin
                r_ex <= 16'(r_bx) - 16'(r_ax);
                r_ey <= 16'(r_by) - 16'(r_ay);
                r_qx <= 16'(r_px) - 16'(r_ax);
                r_qy <= 16'(r_py) - 16'(r_ay);
                r_rx <= 16'(r_bx) - 16'(r_px);
                r_ry <= 16'(r_by) - 16'(r_py);
            end
            OP_MX1, OP_LEN0, OP_DOT0, OP_PT0: r_acc <= prod;
            OP_MX2:  r_cr   <= 33'(r_acc - prod);
            OP_LEN1: r_len2 <= 32'(r_acc + prod);
            OP_DOT1: r_dot  <= 33'(r_acc + prod);
            OP_PT1:  r_d2   <= 32'(r_acc + prod);
            OP_MAG:  r_num  <= 64'(prod);
            OP_SIGN: begin
                if (opposite) begin
                    r_in_zone <= 1'b0;
                end
                r_prev_pos <= cr_pos;
                r_prev_neg <= cr_neg;
            end
            OP_DVI: begin
                r_rem <= r_num[63:32];
                r_num <= {r_num[31:0], 32'd0};
                r_d2  <= 32'd0;
            end
            OP_DVS: begin
                r_rem <= div_ge ? 32'(div_t - {1'b0, r_len2}) : div_t[31:0];
                r_num <= {r_num[62:0], 1'b0};
                r_d2  <= {r_d2[30:0], div_ge};
            end
            OP_SQI: begin
                r_rem  <= r_d2;
                r_root <= 32'd0;
                r_bit  <= 32'h4000_0000;
            end
            OP_SQS: begin
                r_rem  <= sq_ge ? 32'({1'b0, r_rem} - sq_sum) : r_rem;
                r_root <= sq_ge ? (r_root >> 1) + r_bit : r_root >> 1;
                r_bit  <= r_bit >> 2;
            end
            OP_MIN: begin
                if (dsat < r_min) begin
                    r_min <= dsat;
                end
            end
            OP_NEXT: begin
                r_ia   <= ib;
                r_edge <= r_edge + CW'(1);
            end
            OP_RESULT: begin
                r_res_c    <= res_c;
                r_res_last <= r_last;
                r_res_occ  <= r_last && (fc_new != 2'd0);
                r_res_cnt  <= r_last ? fc_new : 2'd0;
                r_res_cv   <= 1'b1;
                if (set_track) begin
                    r_seen[slot_idx] <= r_now;
                end
            end
            OP_EMIT: begin
                r_m_c    <= r_res_c;
                r_m_last <= r_res_last;
                r_m_occ  <= r_res_occ;
                r_m_cnt  <= r_res_cnt;
                r_m_cv   <= r_res_cv;
            end
            default: r_min <= r_min;
        endcase
    end

    always_comb begin
        o_status.vcount_ok  = r_vcount >= CW'(3);
        o_status.present    = r_present;
        o_status.tracked    = tracked;
        o_status.in_zone    = r_in_zone;
        o_status.last_edge  = (r_edge == r_vcount);
        o_status.near_start = near_start;
        o_status.near_end   = near_end;
        o_status.out_free   = out_free;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'd0, r_m_cnt, r_m_occ, r_m_c};
    assign o_m_tuser  = r_m_cv;
    assign o_m_tlast  = r_m_last;

endmodule

@@ src/zone_occupancy_tracker.sv @@
// Top level of the zone occupancy tracker: controller plus datapath.
// A present target is processed edge by edge over vertex_count + 1 polygon edges, ending early
// once outside the zone and untracked; tracked, each edge adds a distance (32-step divide unless
// near an end point, 16-step square root). An absent target goes straight to its result.
// One request is processed at a time; the result waits in an output register.
// Synchronous active-low reset clears control state, counts, output valid and tracking.
module zone_occupancy_tracker import zot_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_TARGETS  = MAX_TARGETS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // vertex_index, last_vertex, target_slot, present, x, y, time_ms, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [1:0]             s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // contained, occupied, contained count, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // count_valid
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_dp_op     op;
    t_dp_status status;

    zot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_op       (op)
    );

    zot_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_TARGETS  (MAX_TARGETS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tlast   (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (m_axis_tready),
        .o_status    (status),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

@@ src/zot_checker.sv @@
// Port-level checker for the zone occupancy tracker, bound to the top level.
// Depends on zot_pkg.
module zot_checker import zot_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser,
    input logic                   m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_unavail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("unavailable result malformed");

    a_midframe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[3:1] == 3'd0)
        else $error("frame summary outside frame end");

    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1] == (m_axis_tdata[3:2] != 2'd0))
        else $error("occupied disagrees with count");

endmodule

bind zone_occupancy_tracker zot_checker u_zot_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
